>>> rtl/core/gge_pkg.sv
// Shared types, tables and functions for the garbled gate evaluator
`default_nettype none

package gge_pkg;

    localparam int NUM_KEY_CELLS = 10;
    localparam int NUM_RND_CELLS = 20;

    // input transfer: two wire labels and the four garbled rows
    typedef struct packed {
        logic [63:0] label_a_lo;
        logic [63:0] label_a_hi;
        logic [63:0] label_b_lo;
        logic [63:0] label_b_hi;
        logic [63:0] row0_lo;
        logic [63:0] row0_hi;
        logic [63:0] row1_lo;
        logic [63:0] row1_hi;
        logic [63:0] row2_lo;
        logic [63:0] row2_hi;
        logic [63:0] row3_lo;
        logic [63:0] row3_hi;
    } gate_item_t;

    // result transfer
    typedef struct packed {
        logic [63:0] out_label_lo;
        logic [63:0] out_label_hi;
        logic [1:0]  row_used;
    } result_item_t;

    // payload moving through the key expansion cells
    typedef struct packed {
        logic [127:0] state;
        logic [127:0] key_a;
        logic [127:0] key_b;
        logic [1:0]   row_used;
    } key_item_t;

    // payload moving through the inverse round cells
    typedef struct packed {
        logic [127:0] state;
        logic [127:0] key_cur;
        logic [127:0] key_oth;
        logic [1:0]   row_used;
    } rnd_item_t;

    // byte 0 sits in the top byte of each table
    localparam logic [2047:0] SBOX_VEC = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [2047:0] INV_SBOX_VEC = {
        128'h52096ad53036a538bf40a39e81f3d7fb,
        128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e,
        128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692,
        128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506,
        128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673,
        128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b,
        128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f,
        128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961,
        128'h172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX_VEC[{~x, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        return INV_SBOX_VEC[{~x, 3'b000} +: 8];
    endfunction

    // round constant used to produce round key j
    function automatic logic [7:0] rcon(input int j);
        logic [7:0] rc;
        unique case (j)
            1:       rc = 8'h01;
            2:       rc = 8'h02;
            3:       rc = 8'h04;
            4:       rc = 8'h08;
            5:       rc = 8'h10;
            6:       rc = 8'h20;
            7:       rc = 8'h40;
            8:       rc = 8'h80;
            9:       rc = 8'h1b;
            10:      rc = 8'h36;
            default: rc = 8'h00;
        endcase
        return rc;
    endfunction

    // rotate, substitute and add round constant on one key word
    function automatic logic [31:0] key_g(input logic [31:0] w, input logic [7:0] rc);
        return {sbox(w[7:0]), sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]) ^ rc};
    endfunction

    // next round key
    function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] n0, n1, n2, n3;
        n0 = k[31:0] ^ key_g(k[127:96], rc);
        n1 = k[63:32] ^ n0;
        n2 = k[95:64] ^ n1;
        n3 = k[127:96] ^ n2;
        return {n3, n2, n1, n0};
    endfunction

    // previous round key
    function automatic logic [127:0] key_bwd(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] p0, p1, p2, p3;
        p3 = k[127:96] ^ k[95:64];
        p2 = k[95:64] ^ k[63:32];
        p1 = k[63:32] ^ k[31:0];
        p0 = k[31:0] ^ key_g(p3, rc);
        return {p3, p2, p1, p0};
    endfunction

    function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[8*(r+4*c) +: 8] = inv_sbox(s[8*(r+4*((c-r+4)%4)) +: 8]);
            end
        end
        return t;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a1, a2, a4, a8;
        logic [7:0]   m9 [4];
        logic [7:0]   m11 [4];
        logic [7:0]   m13 [4];
        logic [7:0]   m14 [4];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a1 = s[8*(4*c+r) +: 8];
                a2 = xtime(a1);
                a4 = xtime(a2);
                a8 = xtime(a4);
                m9[r]  = a8 ^ a1;
                m11[r] = a8 ^ a2 ^ a1;
                m13[r] = a8 ^ a4 ^ a1;
                m14[r] = a8 ^ a4 ^ a2;
            end
            t[8*(4*c+0) +: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
            t[8*(4*c+1) +: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
            t[8*(4*c+2) +: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
            t[8*(4*c+3) +: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
        end
        return t;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/gge_chan_if.sv
// Valid/ready channel interface carrying one payload type
`default_nettype none

interface gge_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/core/garbled_gate_evaluator_top.sv
// Pipeline: 10 key cells, then 20 round cells, from gate transfer to result.
// Throughput: one gate per cycle unless result stalls; each cell is one register.
// Each cell holds its item while the next one is full and stalled, so gaps close.
// Reset: rst_n asynchronously clears every cell valid bit; payloads are not reset.
`default_nettype none

module garbled_gate_evaluator_top
    import gge_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    gge_chan_if.sink   gate,
    gge_chan_if.source result
);

    logic      kv [NUM_KEY_CELLS+1];
    logic      kr [NUM_KEY_CELLS+1];
    key_item_t kp [NUM_KEY_CELLS+1];
    logic      rv [NUM_RND_CELLS+1];
    logic      rr [NUM_RND_CELLS+1];
    rnd_item_t rp [NUM_RND_CELLS+1];
    gate_item_t g;
    logic [1:0] idx;

    // row select from the two permute bits
    always_comb
    begin
        g   = gate.payload;
        idx = {g.label_b_lo[0], g.label_a_lo[0]};
        kp[0].key_a    = {g.label_a_hi, g.label_a_lo};
        kp[0].key_b    = {g.label_b_hi, g.label_b_lo};
        kp[0].row_used = idx;
        unique case (idx)
            2'd0:    kp[0].state = {g.row0_hi, g.row0_lo};
            2'd1:    kp[0].state = {g.row1_hi, g.row1_lo};
            2'd2:    kp[0].state = {g.row2_hi, g.row2_lo};
            default: kp[0].state = {g.row3_hi, g.row3_lo};
        endcase
    end

    assign kv[0]      = gate.valid;
    assign gate.ready = kr[0];

    // key expansion chain
    for (genvar i = 0; i < NUM_KEY_CELLS; i++)
    begin : g_key
        gge_key_cell #(.RND(i + 1)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (kv[i]),
            .up_ready (kr[i]),
            .up_data  (kp[i]),
            .dn_valid (kv[i+1]),
            .dn_ready (kr[i+1]),
            .dn_data  (kp[i+1])
        );
    end

    // hand the last round keys to the inverse rounds, label b first
    assign rv[0]            = kv[NUM_KEY_CELLS];
    assign kr[NUM_KEY_CELLS] = rr[0];
    assign rp[0].state      = kp[NUM_KEY_CELLS].state;
    assign rp[0].key_cur    = kp[NUM_KEY_CELLS].key_b;
    assign rp[0].key_oth    = kp[NUM_KEY_CELLS].key_a;
    assign rp[0].row_used   = kp[NUM_KEY_CELLS].row_used;

    // inverse round chain: ten rounds under label b, ten under label a
    for (genvar i = 0; i < NUM_RND_CELLS; i++)
    begin : g_rnd
        gge_round_cell #(
            .RND     (9 - (i % 10)),
            .HANDOFF (i == 9)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (rv[i]),
            .up_ready (rr[i]),
            .up_data  (rp[i]),
            .dn_valid (rv[i+1]),
            .dn_ready (rr[i+1]),
            .dn_data  (rp[i+1])
        );
    end

    // result transfer
    assign result.valid                = rv[NUM_RND_CELLS];
    assign rr[NUM_RND_CELLS]           = result.ready;
    assign result.payload.out_label_lo = rp[NUM_RND_CELLS].state[63:0];
    assign result.payload.out_label_hi = rp[NUM_RND_CELLS].state[127:64];
    assign result.payload.row_used     = rp[NUM_RND_CELLS].row_used;

endmodule

`default_nettype wire

>>> rtl/core/gge_key_cell.sv
// One key expansion cell: advances both label keys by one round
`default_nettype none

module gge_key_cell
    import gge_pkg::*;
#(
    parameter int RND = 1
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      up_valid,
    output logic           up_ready,
    input  wire key_item_t up_data,
    output logic           dn_valid,
    input  wire logic      dn_ready,
    output key_item_t      dn_data
);

    logic      valid_reg;
    key_item_t data_reg;
    key_item_t data_next;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    // expand both keys; the last cell also whitens the row with key b
    always_comb
    begin
        data_next          = up_data;
        data_next.key_a    = key_fwd(up_data.key_a, rcon(RND));
        data_next.key_b    = key_fwd(up_data.key_b, rcon(RND));
        if (RND == NUM_KEY_CELLS)
        begin
            data_next.state = up_data.state ^ data_next.key_b;
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/gge_round_cell.sv
// One inverse cipher round cell with backward key step
`default_nettype none

module gge_round_cell
    import gge_pkg::*;
#(
    parameter int RND     = 9,
    parameter bit HANDOFF = 1'b0
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      up_valid,
    output logic           up_ready,
    input  wire rnd_item_t up_data,
    output logic           dn_valid,
    input  wire logic      dn_ready,
    output rnd_item_t      dn_data
);

    logic         valid_reg;
    rnd_item_t    data_reg;
    rnd_item_t    data_next;
    logic [127:0] rkey;
    logic [127:0] added;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    // inverse round; at the end of the first cipher switch to the other key
    always_comb
    begin
        rkey      = key_bwd(up_data.key_cur, rcon(RND + 1));
        added     = inv_shift_sub(up_data.state) ^ rkey;
        data_next = up_data;
        if (RND != 0)
        begin
            data_next.state   = inv_mix(added);
            data_next.key_cur = rkey;
        end
        else if (HANDOFF)
        begin
            data_next.state   = added ^ up_data.key_oth;
            data_next.key_cur = up_data.key_oth;
        end
        else
        begin
            data_next.state   = added;
            data_next.key_cur = rkey;
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

>>> dv/gge_result_checker.sv
// Checker that predicts garbled gate results and compares them at the result channel
module gge_result_checker
    import gge_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         gate_valid,
    input  logic         gate_ready,
    input  gate_item_t   gate_payload,
    input  logic         result_valid,
    input  logic         result_ready,
    input  result_item_t result_payload,
    output int           fail_count,
    output int           pending_count
);

    result_item_t label_queue[$];

    // galois field multiply, shift and add
    function automatic logic [7:0] gmul(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (y[0])
                p ^= x;
            x = x[7] ? ({x[6:0], 1'b0} ^ 8'h1b) : {x[6:0], 1'b0};
            y = y >> 1;
        end
        return p;
    endfunction

    // forward substitution built from the field inverse and affine map
    function automatic logic [7:0] fwd_sub(input logic [7:0] x);
        logic [7:0] inv;
        logic [7:0] s;
        inv = 8'h01;
        for (int i = 0; i < 254; i++)
            inv = gmul(inv, x);
        if (x == 8'h00)
            inv = 8'h00;
        s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
            ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        return s;
    endfunction

    logic [7:0] fbox [256];
    logic [7:0] ibox [256];

    initial
    begin
        for (int x = 0; x < 256; x++)
        begin
            fbox[x] = fwd_sub(x[7:0]);
            ibox[fbox[x]] = x[7:0];
        end
    end

    // full decryption of one block, bytes indexed 0..15
    function automatic logic [127:0] decrypt_block(input logic [127:0] key,
                                                   input logic [127:0] blk);
        logic [7:0] rk [176];
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] w [4];
        logic [7:0] rc;
        logic [7:0] f;
        logic [127:0] res;
        rc = 8'h01;
        for (int i = 0; i < 16; i++)
        begin
            rk[i] = key[8*i +: 8];
            s[i] = blk[8*i +: 8];
        end
        for (int i = 4; i < 44; i++)
        begin
            for (int j = 0; j < 4; j++)
                w[j] = rk[4*(i-1)+j];
            if ((i % 4) == 0)
            begin
                f = w[0];
                w[0] = fbox[w[1]] ^ rc;
                w[1] = fbox[w[2]];
                w[2] = fbox[w[3]];
                w[3] = fbox[f];
                rc = gmul(rc, 8'h02);
            end
            for (int j = 0; j < 4; j++)
                rk[4*i+j] = rk[4*(i-4)+j] ^ w[j];
        end
        for (int i = 0; i < 16; i++)
            s[i] ^= rk[160+i];
        for (int r = 9; r >= 0; r--)
        begin
            for (int c = 0; c < 4; c++)
                for (int q = 0; q < 4; q++)
                    t[q+4*c] = ibox[s[q+4*((c-q+4)%4)]];
            for (int i = 0; i < 16; i++)
                s[i] = t[i] ^ rk[16*r+i];
            if (r > 0)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    t[0] = s[4*c]; t[1] = s[4*c+1]; t[2] = s[4*c+2]; t[3] = s[4*c+3];
                    s[4*c]   = gmul(t[0], 8'd14) ^ gmul(t[1], 8'd11)
                               ^ gmul(t[2], 8'd13) ^ gmul(t[3], 8'd9);
                    s[4*c+1] = gmul(t[0], 8'd9) ^ gmul(t[1], 8'd14)
                               ^ gmul(t[2], 8'd11) ^ gmul(t[3], 8'd13);
                    s[4*c+2] = gmul(t[0], 8'd13) ^ gmul(t[1], 8'd9)
                               ^ gmul(t[2], 8'd14) ^ gmul(t[3], 8'd11);
                    s[4*c+3] = gmul(t[0], 8'd11) ^ gmul(t[1], 8'd13)
                               ^ gmul(t[2], 8'd9) ^ gmul(t[3], 8'd14);
                end
            end
        end
        for (int i = 0; i < 16; i++)
            res[8*i +: 8] = s[i];
        return res;
    endfunction

    // select the row by permute bits, then peel off both encryption layers
    function automatic result_item_t evaluate_gate(input gate_item_t g);
        result_item_t e;
        logic [1:0]   sel;
        logic [127:0] row;
        logic [127:0] plain;
        sel = {g.label_b_lo[0], g.label_a_lo[0]};
        case (sel)
            2'd0:    row = {g.row0_hi, g.row0_lo};
            2'd1:    row = {g.row1_hi, g.row1_lo};
            2'd2:    row = {g.row2_hi, g.row2_lo};
            default: row = {g.row3_hi, g.row3_lo};
        endcase
        plain = decrypt_block({g.label_b_hi, g.label_b_lo}, row);
        plain = decrypt_block({g.label_a_hi, g.label_a_lo}, plain);
        e.out_label_lo = plain[63:0];
        e.out_label_hi = plain[127:64];
        e.row_used = sel;
        return e;
    endfunction

    assign pending_count = label_queue.size();

    // predict on gate transfer, compare on result transfer
    always @(posedge clk)
    begin
        result_item_t want;
        if (rst_n)
        begin
            if (gate_valid && gate_ready)
                label_queue = {label_queue, evaluate_gate(gate_payload)};
            if (result_valid && result_ready)
            begin
                if (label_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transfer: %h", result_payload);
                end
                else
                begin
                    want = label_queue.pop_front();
                    if (want.out_label_lo !== result_payload.out_label_lo
                        || want.out_label_hi !== result_payload.out_label_hi
                        || want.row_used !== result_payload.row_used)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("label mismatch: expected lo %h hi %h row %0d, got lo %h hi %h row %0d",
                                     want.out_label_lo, want.out_label_hi, want.row_used,
                                     result_payload.out_label_lo, result_payload.out_label_hi,
                                     result_payload.row_used);
                    end
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

>>> dv/garbled_gate_evaluator_top_test.sv
// Testbench top: drives gates into the evaluator and gives the verdict
module garbled_gate_evaluator_top_test;
    import gge_pkg::*;

    localparam int RANDOM_GATES = 600;
    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   cycle_count;
    logic sink_stall;
    logic src_busy;
    logic hold_sink;

    gge_chan_if #(.T(gate_item_t))   gate_ch ();
    gge_chan_if #(.T(result_item_t)) result_ch ();

    garbled_gate_evaluator_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .gate   (gate_ch.sink),
        .result (result_ch.source)
    );

    gge_result_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .gate_valid     (gate_ch.valid),
        .gate_ready     (gate_ch.ready),
        .gate_payload   (gate_ch.payload),
        .result_valid   (result_ch.valid),
        .result_ready   (result_ch.ready),
        .result_payload (result_ch.payload),
        .fail_count     (fail_count),
        .pending_count  (pending_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // cycle limit
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("garbled_gate_evaluator_top test failed");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // pick a corner or random 64-bit word
    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 64'h0;
            1:       return '1;
            2:       return 64'h1;
            3:       return ~64'h1;
            default: return rand64();
        endcase
    endfunction

    function automatic gate_item_t random_gate();
        gate_item_t g;
        g = {rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
             rand64(), rand64(), rand64(), rand64(), rand64(), rand64()};
        if ($urandom_range(0, 3) == 0)
        begin
            g.label_a_lo = pick_word();
            g.label_b_hi = pick_word();
            g.row2_lo = pick_word();
        end
        return g;
    endfunction

    // sink side ready: random stalls, a quiet stretch, and a long hold-off
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_sink)
                result_ch.ready <= 1'b0;
            else if (!sink_stall)
                result_ch.ready <= 1'b1;
            else
                result_ch.ready <= ($urandom_range(0, 99) >= 24);
        end
    end

    // one gate transfer with optional random idling before it
    task automatic send_gate(input gate_item_t g);
        while (src_busy && $urandom_range(0, 99) < 24)
        begin
            gate_ch.valid <= 1'b0;
            @(negedge clk);
        end
        gate_ch.valid <= 1'b1;
        gate_ch.payload <= g;
        @(posedge clk);
        while (!gate_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        gate_ch.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    initial
    begin
        gate_item_t g;
        rst_n = 1'b0;
        gate_ch.valid = 1'b0;
        gate_ch.payload = '0;
        sink_stall = 1'b0;
        src_busy = 1'b0;
        hold_sink = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: every row select, all-zero and all-one fields
        g = '0;
        send_gate(g);
        g = '1;
        send_gate(g);
        for (int sel = 0; sel < 4; sel++)
        begin
            g = random_gate();
            g.label_a_lo[0] = sel[0];
            g.label_b_lo[0] = sel[1];
            send_gate(g);
            g = '0;
            g.label_a_lo[0] = sel[0];
            g.label_b_lo[0] = sel[1];
            send_gate(g);
            g = '1;
            g.label_a_lo[0] = sel[0];
            g.label_b_lo[0] = sel[1];
            send_gate(g);
        end
        // equal labels as keys
        g = random_gate();
        g.label_b_lo = g.label_a_lo;
        g.label_b_hi = g.label_a_hi;
        send_gate(g);
        drain_results();

        // long receiver hold-off while gates keep arriving
        hold_sink = 1'b1;
        fork
            begin
                repeat (80) @(negedge clk);
                hold_sink = 1'b0;
            end
            begin
                for (int i = 0; i < 60; i++)
                    send_gate(random_gate());
            end
        join
        drain_results();

        // random phase, no idling first, then idling on both sides
        for (int i = 0; i < RANDOM_GATES; i++)
        begin
            if (i == 100)
            begin
                sink_stall = 1'b1;
                src_busy = 1'b1;
            end
            if (i == 400)
                drain_results();
            send_gate(random_gate());
        end
        drain_results();
        repeat (40) @(negedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("garbled_gate_evaluator_top test passed");
        else
            $display("garbled_gate_evaluator_top test failed");
        $finish;
    end

endmodule
